// File: rtl/core/wsenc_pkg.sv
// Shared types and constants for the WebSocket masked frame encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package wsenc_pkg;

  localparam int LEN_W = 63;
  localparam int KEY_W = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic [7:0] HDR_BYTE   = 8'h81;
  localparam logic [7:0] MASK_BIT   = 8'h80;
  localparam logic [7:0] LEN_CODE16 = 8'd126;
  localparam logic [7:0] LEN_CODE64 = 8'd127;
  localparam logic [LEN_W-1:0] LEN_SHORT_MAX = LEN_W'(125);
  localparam logic [LEN_W-1:0] LEN16_MAX     = LEN_W'(65535);

  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [1:0] KEY_LAST   = 2'd3;

  typedef struct packed {
    logic             is_start;
    logic [7:0]       byte_val;
    logic             last;
    logic             has_ext;
    logic [2:0]       ext_last;
    logic [63:0]      ext;
    logic [KEY_W-1:0] key;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LEN,
    BK_EXT,
    BK_KEY
  } back_state_t;

endpackage

// File: rtl/core/wsenc_front.sv
// Front end: takes items, tracks the open frame, makes jobs of starts and frame bytes.
// Depends on wsenc_pkg.
module wsenc_front
  import wsenc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             cmd,
  input  logic [LEN_W-1:0] payload_length,
  input  logic [KEY_W-1:0] mask_key,
  input  logic [7:0]       data_byte,
  output logic             push,
  output job_t             job
);

  logic             frame_open_r, frame_open_nxt;
  logic [LEN_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [1:0]       kidx_r, kidx_nxt;
  logic [LEN_W-1:0] left_dec;
  logic [7:0]       key_byte;
  logic             is_short;
  logic             is_mid;

  assign left_dec = bytes_left_r - LEN_W'(1);
  assign is_short = (payload_length <= LEN_SHORT_MAX);
  assign is_mid   = (payload_length <= LEN16_MAX);

  always_comb begin
    unique case (kidx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    key_nxt        = key_r;
    kidx_nxt       = kidx_r;
    push           = 1'b0;
    job            = '0;
    job.key        = mask_key;
    if (accept) begin
      if (cmd == CMD_START) begin
        push           = 1'b1;
        job.is_start   = 1'b1;
        job.last       = (payload_length == '0);
        job.has_ext    = !is_short;
        if (is_short) begin
          job.byte_val = MASK_BIT | payload_length[7:0];
        end else if (is_mid) begin
          job.byte_val = MASK_BIT | LEN_CODE16;
        end else begin
          job.byte_val = MASK_BIT | LEN_CODE64;
        end
        if (is_mid) begin
          job.ext_last = EXT16_LAST;
          job.ext      = {payload_length[15:0], 48'd0};
        end else begin
          job.ext_last = EXT64_LAST;
          job.ext      = {1'b0, payload_length};
        end
        frame_open_nxt = (payload_length != '0);
        bytes_left_nxt = payload_length;
        key_nxt        = mask_key;
        kidx_nxt       = 2'd0;
      end else if (frame_open_r) begin
        push           = 1'b1;
        job.byte_val   = data_byte ^ key_byte;
        job.last       = (left_dec == '0);
        bytes_left_nxt = left_dec;
        kidx_nxt       = kidx_r + 2'd1;
        frame_open_nxt = (left_dec != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
    end else begin
      frame_open_r <= frame_open_nxt;
    end
    bytes_left_r <= bytes_left_nxt;
    key_r        <= key_nxt;
    kidx_r       <= kidx_nxt;
  end

endmodule

// File: rtl/core/wsenc_queue.sv
// Short job queue between the front end and the back end.
// Depends on wsenc_pkg for the job type.
module wsenc_queue
  import wsenc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/core/wsenc_back.sv
// Back end: expands start jobs into header bytes and drives the output register.
// Depends on wsenc_pkg.
module wsenc_back
  import wsenc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job,
  output logic       pop,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_frame_last
);

  back_state_t      state_r, state_nxt;
  logic [7:0]       len_byte_r;
  logic             has_ext_r;
  logic             empty_r;
  logic [63:0]      ext_r;
  logic [2:0]       ext_cnt_r;
  logic [2:0]       ext_last_r;
  logic [KEY_W-1:0] key_r;
  logic [1:0]       key_cnt_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             adv;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             emit_last;

  assign adv = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    if (adv) begin
      unique case (state_r)
        BK_IDLE: begin
          if (job_valid && job.is_start) begin
            state_nxt = BK_LEN;
          end
        end
        BK_LEN: state_nxt = has_ext_r ? BK_EXT : BK_KEY;
        BK_EXT: begin
          if (ext_cnt_r == ext_last_r) begin
            state_nxt = BK_KEY;
          end
        end
        BK_KEY: begin
          if (key_cnt_r == KEY_LAST) begin
            state_nxt = BK_IDLE;
          end
        end
        default: state_nxt = BK_IDLE;
      endcase
    end
  end

  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    emit_byte = '0;
    emit_last = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        pop       = adv && job_valid;
        emit      = pop;
        emit_byte = job.is_start ? HDR_BYTE : job.byte_val;
        emit_last = !job.is_start && job.last;
      end
      BK_LEN: begin
        emit      = adv;
        emit_byte = len_byte_r;
      end
      BK_EXT: begin
        emit      = adv;
        emit_byte = ext_r[63:56];
      end
      BK_KEY: begin
        emit      = adv;
        emit_byte = key_r[31:24];
        emit_last = empty_r && (key_cnt_r == KEY_LAST);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        out_valid_r <= emit;
      end
    end
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
    if (pop && job.is_start) begin
      len_byte_r <= job.byte_val;
      has_ext_r  <= job.has_ext;
      empty_r    <= job.last;
      ext_r      <= job.ext;
      ext_cnt_r  <= '0;
      ext_last_r <= job.ext_last;
      key_r      <= job.key;
      key_cnt_r  <= '0;
    end else if (adv && state_r == BK_EXT) begin
      ext_r     <= {ext_r[55:0], 8'd0};
      ext_cnt_r <= ext_cnt_r + 3'd1;
    end else if (adv && state_r == BK_KEY) begin
      key_r     <= {key_r[KEY_W-9:0], 8'd0};
      key_cnt_r <= key_cnt_r + 2'd1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_frame_last = out_last_r;

endmodule

// File: rtl/core/websocket_masked_frame_encoder.sv
// Top level of the WebSocket client text-frame encoder with masking.
// Instantiates wsenc_front, wsenc_queue and wsenc_back; depends on wsenc_pkg.
//
// A start item produces the frame header as 6, 8 or 14 output bytes (header byte, length
// byte, optional 16-bit or 64-bit length extension, four key bytes), one byte per cycle from
// the back end's header sequencer while the output is not stalled. Each payload byte of an
// open frame produces one masked byte; payload bytes with no open frame are taken and dropped.
// Input is accepted every cycle while the job queue has room, so payload streams at one byte
// per cycle and a header stalls the input only once the queue fills. The output register
// holds a byte while out_stall is high; the queue stops draining but takes input until full.
module websocket_masked_frame_encoder
  import wsenc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_cmd,
  input  logic [LEN_W-1:0] in_payload_length,
  input  logic [KEY_W-1:0] in_mask_key,
  input  logic [7:0]       in_data_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_frame_last
);

  logic accept;
  logic push;
  job_t push_job;
  logic pop;
  logic full;
  logic not_empty;
  job_t head;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  wsenc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .cmd            (in_cmd),
    .payload_length (in_payload_length),
    .mask_key       (in_mask_key),
    .data_byte      (in_data_byte),
    .push           (push),
    .job            (push_job)
  );

  wsenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  wsenc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (not_empty),
    .job            (head),
    .pop            (pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .out_frame_last (out_frame_last)
  );

endmodule
